[rtl/hcv_pkg.sv]
// ----------------------------------------------------------------------------
// Hamming codec package
// Field widths, operation and status codes, the length record and the
// elaboration-time helpers that derive the parity count from the message length.
// ----------------------------------------------------------------------------
package hcv_pkg;

   localparam int WORD_W   = 64;
   localparam int SYN_W    = 7;
   localparam int STATUS_W = 2;
   localparam int PAR_W    = 3;
   localparam int NLEN_W   = 6;
   localparam int TOTAL_W  = 7;
   localparam int RSP_W    = ((WORD_W + SYN_W + STATUS_W + PAR_W + 7) / 8) * 8;

   localparam int MAX_CODE_BITS_DEFAULT = 64;

   localparam logic [NLEN_W-1:0] DATA_BITS_RESET = 6'd4;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CORRECTED    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd2;

   // Effective message length, parity count and codeword length.
   typedef struct packed {
      logic [NLEN_W-1:0]  n;
      logic [PAR_W-1:0]   par;
      logic [TOTAL_W-1:0] total;
   } len_type;

   // Least r with 2^r >= n + r + 1, capped at seven.
   function automatic int parity_for(input int n);
      int r;
      r = 0;
      for (int k = 0; k < 7; k++) begin
         if ((1 << r) < n + r + 1) begin
            r = r + 1;
         end
      end
      return r;
   endfunction

   // Largest message length whose codeword still fits in max_code positions.
   function automatic int max_data_bits(input int max_code);
      int   n;
      logic stop;
      n    = 1;
      stop = 1'b0;
      for (int k = 0; k < 62; k++) begin
         if (!stop && n < 63 && (n + 1) + parity_for(n + 1) <= max_code) begin
            n = n + 1;
         end else begin
            stop = 1'b1;
         end
      end
      return n;
   endfunction

   // Clamps a raw length into 1..nmax and derives the parity and total counts.
   function automatic len_type len_from_raw(input logic [NLEN_W-1:0] raw, input int nmax);
      int      n;
      int      r;
      len_type l;
      n = int'(raw);
      if (n < 1) begin
         n = 1;
      end
      if (n > nmax) begin
         n = nmax;
      end
      r       = parity_for(n);
      l.n     = NLEN_W'(n);
      l.par   = PAR_W'(r);
      l.total = TOTAL_W'(n + r);
      return l;
   endfunction

endpackage

[rtl/hcv_datapath.sv]
// ----------------------------------------------------------------------------
// Hamming codec datapath
// Combinational encode and check/correct of one word for the current length.
// ----------------------------------------------------------------------------
module hcv_datapath (
   input  logic                              op,
   input  logic [hcv_pkg::WORD_W-1:0]        word,
   input  hcv_pkg::len_type                  len,
   output logic [hcv_pkg::WORD_W-1:0]        code_word,
   output logic [hcv_pkg::SYN_W-1:0]         syndrome,
   output logic [hcv_pkg::STATUS_W-1:0]      status
);

   localparam int W = hcv_pkg::WORD_W;

   logic [W-1:0]                data_mask;
   logic [W-1:0]                total_mask;
   logic [W-1:0]                msg;
   logic [W-1:0]                spread;
   logic [W-1:0]                src;
   logic [W-1:0]                enc;
   logic [W-1:0]                flip;
   logic [hcv_pkg::SYN_W-1:0]   check;
   logic                        in_range;

   always_comb begin
      for (int k = 0; k < W; k++) begin
         data_mask[k]  = hcv_pkg::TOTAL_W'(k) < {1'b0, len.n};
         total_mask[k] = hcv_pkg::TOTAL_W'(k) < len.total;
      end
   end

   assign msg = word & data_mask;

   // Message bits go in order to the positions that are not powers of two.
   for (genvar g = 0; g < W; g++) begin : g_spread
      localparam int POS = g + 1;
      localparam int DIX = POS - 1 - $clog2(POS + 1);
      if ((POS & (POS - 1)) == 0) begin : g_par
         assign spread[g] = 1'b0;
      end else begin : g_dat
         assign spread[g] = msg[DIX];
      end
   end

   // On encode the parity positions are still zero, so the same trees give
   // the check bits; on decode they give the syndrome.
   assign src = (op == hcv_pkg::OP_DECODE) ? (word & total_mask) : spread;

   always_comb begin
      check = '0;
      for (int i = 0; i < hcv_pkg::SYN_W; i++) begin
         for (int k = 0; k < W; k++) begin
            if ((((k + 1) >> i) & 1) == 1) begin
               check[i] = check[i] ^ src[k];
            end
         end
      end
   end

   always_comb begin
      enc = spread;
      for (int i = 0; i < hcv_pkg::SYN_W; i++) begin
         if ((1 << i) <= W) begin
            enc[(1 << i) - 1] = check[i];
         end
      end
   end

   assign in_range = check <= len.total;

   always_comb begin
      for (int k = 0; k < W; k++) begin
         flip[k] = (check == hcv_pkg::SYN_W'(k + 1)) && in_range;
      end
   end

   always_comb begin
      if (op == hcv_pkg::OP_DECODE) begin
         code_word = src ^ flip;
         syndrome  = check;
         if (check == '0) begin
            status = hcv_pkg::STATUS_OK;
         end else if (in_range) begin
            status = hcv_pkg::STATUS_CORRECTED;
         end else begin
            status = hcv_pkg::STATUS_OUT_OF_RANGE;
         end
      end else begin
         code_word = enc;
         syndrome  = '0;
         status    = hcv_pkg::STATUS_OK;
      end
   end

endmodule

[rtl/hamming_codec_variable_length_top.sv]
// ----------------------------------------------------------------------------
// Hamming codec with a programmable message length
// Single-error-correcting encoder and checker behind streaming channels.
// ----------------------------------------------------------------------------
// Usage: each request beat carries a 64-bit word and an operation in tuser
// (encode a message, or check and correct a received codeword). Each request
// produces exactly one response beat with the codeword, the syndrome, a status
// code and the parity count in use. The message length is set through the
// csr channel, which always accepts; write it only while no beat is in flight.
// A request beat loads the input register when it is accepted; the output
// register then loads from it through the encode/decode logic whenever it is
// empty or being drained. Throughput is one beat per clock as long as the
// response side keeps taking beats, set by the single pass through the parity
// XOR trees between those two registers.
// A stalled response holds in the output register; the input register still
// accepts one more beat, after which req_tready drops until the response
// side moves. Reset empties both stages and sets the length to four message
// bits (three parity bits, seven-position codeword).
// ----------------------------------------------------------------------------
module hamming_codec_variable_length_top #(
   parameter int MAX_CODE_BITS = hcv_pkg::MAX_CODE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [hcv_pkg::WORD_W-1:0]     req_tdata,   // [63:0] word
   input  logic [0:0]                     req_tuser,   // [0] op
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [63:0] code_word, [70:64] syndrome, [72:71] status, [75:73] parity_count,
   // [79:76] zero
   output logic [hcv_pkg::RSP_W-1:0]      rsp_tdata,
   // Length register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hcv_pkg::NLEN_W-1:0]     csr_data     // data_bits
);

   // Largest message length for the configured codeword size; fixed at build.
   localparam int NMAX = hcv_pkg::max_data_bits(MAX_CODE_BITS);
   localparam hcv_pkg::len_type LEN_RESET =
      hcv_pkg::len_from_raw(hcv_pkg::DATA_BITS_RESET, NMAX);

   localparam int PAD_W = hcv_pkg::RSP_W - hcv_pkg::WORD_W - hcv_pkg::SYN_W -
                          hcv_pkg::STATUS_W - hcv_pkg::PAR_W;

   // Derived length values are kept registered so the datapath sees them
   // directly, without the clamp and parity search in its path.
   hcv_pkg::len_type                len_ff;
   hcv_pkg::len_type                len_in;

   // Input stage.
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            s1_op_ff;
   logic [hcv_pkg::WORD_W-1:0]      s1_word_ff;

   // Output stage.
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [hcv_pkg::WORD_W-1:0]      rsp_code_ff;
   logic [hcv_pkg::SYN_W-1:0]       rsp_syn_ff;
   logic [hcv_pkg::STATUS_W-1:0]    rsp_status_ff;
   logic [hcv_pkg::PAR_W-1:0]       rsp_par_ff;

   logic [hcv_pkg::WORD_W-1:0]      dp_code;
   logic [hcv_pkg::SYN_W-1:0]       dp_syn;
   logic [hcv_pkg::STATUS_W-1:0]    dp_status;

   logic                            req_fire;
   logic                            out_take;

   assign csr_ready = 1'b1;
   assign len_in    = hcv_pkg::len_from_raw(csr_data, NMAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (csr_valid) begin
         len_ff <= len_in;
      end
   end

   // The output register can load whenever it is empty or being drained.
   assign out_take   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_take;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (out_take) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign rsp_valid_in = out_take ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff   <= req_tuser[0];
         s1_word_ff <= req_tdata;
      end
   end

   hcv_datapath u_datapath (
      .op        (s1_op_ff),
      .word      (s1_word_ff),
      .len       (len_ff),
      .code_word (dp_code),
      .syndrome  (dp_syn),
      .status    (dp_status)
   );

   always_ff @(posedge clock) begin
      if (out_take && s1_valid_ff) begin
         rsp_code_ff   <= dp_code;
         rsp_syn_ff    <= dp_syn;
         rsp_status_ff <= dp_status;
         rsp_par_ff    <= len_ff.par;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_par_ff, rsp_status_ff, rsp_syn_ff, rsp_code_ff};

endmodule

[tb/hamming_codec_variable_length_top_test.sv]
// ----------------------------------------------------------------------------
// Hamming codec with programmable length: self-checking testbench
// Drives encode and check/correct beats through the request channel across
// many message lengths, predicts each response from a hand-derived answer or
// an independent model of the code, and compares each response beat field by field in arrival order.
// ----------------------------------------------------------------------------
module hamming_codec_variable_length_top_test;

   localparam int CLK_PERIOD       = 12;
   localparam int CODE_LIMIT       = 64;
   localparam int RUN_LIMIT_CYCLES = 200000;
   localparam int SEGMENTS         = 6;
   localparam int SEGMENT_ITEMS    = 105;
   localparam int HOLD_CYCLES      = 60;
   // The block is two registers deep, so a few cycles cover any beat in flight.
   localparam int SETTLE_CYCLES    = 4;

   localparam int WORD_W   = hcv_pkg::WORD_W;
   localparam int SYN_W    = hcv_pkg::SYN_W;
   localparam int STATUS_W = hcv_pkg::STATUS_W;
   localparam int PAR_W    = hcv_pkg::PAR_W;
   localparam int NLEN_W   = hcv_pkg::NLEN_W;
   localparam int RSP_W    = hcv_pkg::RSP_W;

   // One response beat as the block should deliver it.
   typedef struct packed {
      logic [WORD_W-1:0]   code_word;
      logic [SYN_W-1:0]    syndrome;
      logic [STATUS_W-1:0] status;
      logic [PAR_W-1:0]    parity_count;
   } codec_result_type;

   // One row of the directed table. When typed is set, the result column
   // holds the hand-derived answer; otherwise the model supplies it.
   typedef struct packed {
      logic [NLEN_W-1:0] msg_len;
      logic              op;
      logic [WORD_W-1:0] word;
      logic              typed;
      codec_result_type  result;
   } vector_row_type;

   localparam int DIRECTED_ROWS = 23;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [WORD_W-1:0]   req_tdata  = '0;   // [63:0] word
   logic [0:0]          req_tuser  = '0;   // [0] op
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   // [63:0] code_word, [70:64] syndrome, [72:71] status, [75:73] parity_count,
   // [79:76] zero
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [NLEN_W-1:0]   csr_data   = '0;   // data_bits

   // Testbench copy of the length register.
   logic [NLEN_W-1:0]   length_reg = hcv_pkg::DATA_BITS_RESET;

   // Responses still owed by the block, oldest first.
   codec_result_type    pending_results[$];

   int                  send_idle_pct = 0;
   int                  rcv_idle_pct  = 0;
   bit                  hold_ask      = 1'b0;

   int                  mismatches    = 0;
   int                  beats_sent    = 0;
   int                  beats_checked = 0;
   int                  encodes       = 0;
   int                  decodes       = 0;
   int                  corrections   = 0;
   int                  out_of_range  = 0;
   int                  length_writes = 0;

   vector_row_type      directed_rows [DIRECTED_ROWS];

   hamming_codec_variable_length_top #(
      .MAX_CODE_BITS(CODE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Code arithmetic
   // -------------------------------------------------------------------------

   // Smallest number of check bits that can name every position plus "none".
   function automatic int checks_needed(input int n);
      int r;
      r = 0;
      while ((1 << r) < n + r + 1) r++;
      return r;
   endfunction

   // Effective message length: zero reads as one, and anything whose codeword
   // would not fit in CODE_LIMIT positions is pulled down to the longest fit.
   function automatic int message_length(input logic [NLEN_W-1:0] raw);
      int n;
      int nmax;
      nmax = 1;
      while (nmax < 63 && (nmax + 1) + checks_needed(nmax + 1) <= CODE_LIMIT) nmax++;
      n = int'(raw);
      if (n < 1) n = 1;
      if (n > nmax) n = nmax;
      return n;
   endfunction

   // Ones at bit positions 0..total-1, that is codeword positions 1..total.
   function automatic logic [WORD_W-1:0] position_mask(input int total);
      if (total >= WORD_W) return '1;
      return (64'd1 << total) - 64'd1;
   endfunction

   // Positions 1..total whose number shares a set bit with p; for p = 2^i, what check bit i covers.
   function automatic logic [WORD_W-1:0] cover_mask(input int p, input int total);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int pos = 1; pos <= total; pos++) begin
         if ((pos & p) != 0) m[pos-1] = 1'b1;
      end
      return m;
   endfunction

   // Full response for one request beat under a given raw length setting.
   function automatic codec_result_type hamming_outcome(input logic [NLEN_W-1:0] raw,
                                                        input logic op,
                                                        input logic [WORD_W-1:0] word);
      int                n;
      int                r;
      int                total;
      int                d;
      logic [WORD_W-1:0] cw;
      logic [SYN_W-1:0]  syn;
      codec_result_type  res;
      n     = message_length(raw);
      r     = checks_needed(n);
      total = n + r;
      cw    = '0;
      syn   = '0;
      res.status = hcv_pkg::STATUS_OK;
      if (op == hcv_pkg::OP_ENCODE) begin
         // Message bits fill the non-power-of-two positions in order.
         d = 0;
         for (int pos = 1; pos <= total; pos++) begin
            if ((pos & (pos - 1)) != 0) begin
               cw[pos-1] = word[d];
               d++;
            end
         end
         // Check positions never cover each other, so the order is free.
         for (int i = 0; i < r; i++) begin
            cw[(1 << i) - 1] = ^(cw & cover_mask(1 << i, total));
         end
      end else begin
         cw = word & position_mask(total);
         for (int i = 0; i < r; i++) begin
            syn[i] = ^(cw & cover_mask(1 << i, total));
         end
         if (syn != '0) begin
            if (int'(syn) <= total) begin
               cw[int'(syn) - 1] = ~cw[int'(syn) - 1];
               res.status = hcv_pkg::STATUS_CORRECTED;
            end else begin
               // A syndrome past the end names no position: leave the word alone.
               res.status = hcv_pkg::STATUS_OUT_OF_RANGE;
            end
         end
      end
      res.code_word    = cw;
      res.syndrome     = syn;
      res.parity_count = PAR_W'(r);
      return res;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers. All of them start and end at a falling clock edge.
   // -------------------------------------------------------------------------

   // Offers one request beat, with random idle cycles in front of it, and
   // records the owed response once the beat is accepted.
   task automatic send_beat(input logic op, input logic [WORD_W-1:0] word,
                            input logic typed, input codec_result_type typed_result);
      codec_result_type owed;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= word;
      req_tuser[0] <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      owed = typed ? typed_result : hamming_outcome(length_reg, op, word);
      pending_results.push_back(owed);
      beats_sent++;
      if (op == hcv_pkg::OP_ENCODE) encodes++;
      else decodes++;
      if (owed.status == hcv_pkg::STATUS_CORRECTED) corrections++;
      if (owed.status == hcv_pkg::STATUS_OUT_OF_RANGE) out_of_range++;
      @(negedge clock);
   endtask

   // Lets every owed response come back, then a few more cycles so nothing
   // is left inside the block.
   task automatic wait_for_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Stops the sender, drains the block, then writes the length register.
   task automatic write_length(input logic [NLEN_W-1:0] value);
      req_tvalid <= 1'b0;
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      length_reg = value;
      length_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Builds one random request beat. Most decodes start from a valid codeword
   // with zero, one or two flipped bits and junk above the codeword; the rest
   // are raw noise, which also reaches syndromes past the codeword end.
   task automatic random_beat(output logic op, output logic [WORD_W-1:0] word);
      int                n;
      int                total;
      int                pick;
      int                flips;
      logic [WORD_W-1:0] msg;
      logic [WORD_W-1:0] junk;
      codec_result_type  clean;
      n     = message_length(length_reg);
      total = n + checks_needed(n);
      msg   = {$urandom, $urandom};
      junk  = {$urandom, $urandom};
      pick  = $urandom_range(0, 99);
      if (pick < 35) begin
         op   = hcv_pkg::OP_ENCODE;
         word = msg;
      end else if (pick < 85) begin
         op    = hcv_pkg::OP_DECODE;
         clean = hamming_outcome(length_reg, hcv_pkg::OP_ENCODE, msg);
         word  = clean.code_word;
         flips = $urandom_range(0, 9);
         flips = (flips < 4) ? 0 : (flips < 9) ? 1 : 2;
         for (int k = 0; k < flips; k++) begin
            word[$urandom_range(1, total) - 1] ^= 1'b1;
         end
         word = word | (junk & ~position_mask(total));
      end else begin
         op   = hcv_pkg::OP_DECODE;
         word = junk;
      end
   endtask

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      mismatches++;
      $display("MISMATCH @%0t beat %0d: %s got %h want %h",
               $realtime, beats_checked, what, got, want);
   endtask

   // Every accepted response beat is matched against the oldest owed result.
   always @(posedge clock) begin : rsp_check
      codec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response beat", rsp_tdata[63:0], '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[63:0] !== want.code_word)
               report_mismatch("code_word", rsp_tdata[63:0], want.code_word);
            if (rsp_tdata[70:64] !== want.syndrome)
               report_mismatch("syndrome", 64'(rsp_tdata[70:64]), 64'(want.syndrome));
            if (rsp_tdata[72:71] !== want.status)
               report_mismatch("status", 64'(rsp_tdata[72:71]), 64'(want.status));
            if (rsp_tdata[75:73] !== want.parity_count)
               report_mismatch("parity_count", 64'(rsp_tdata[75:73]),
                               64'(want.parity_count));
            if (rsp_tdata[79:76] !== 4'd0)
               report_mismatch("padding", 64'(rsp_tdata[79:76]), '0);
         end
         beats_checked++;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Random back-pressure, plus a long hold-off on request that is
   // counted here so the sender keeps offering beats meanwhile and the block
   // backs up into its request channel.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_left = HOLD_CYCLES;
            hold_ask  = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   // Safety net: a hung handshake ends the run as a failure.
   initial begin : watchdog
      #(CLK_PERIOD * RUN_LIMIT_CYCLES);
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("hamming_codec_variable_length_top_test: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : main_seq
      logic [NLEN_W-1:0] extremes [8];
      logic [NLEN_W-1:0] next_len;
      logic              op;
      logic [WORD_W-1:0] word;

      extremes = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd57, 6'd58, 6'd63};

      // Directed rows. The first group runs at the reset length of four
      // message bits, so it also checks the reset value of the register.
      // All-ones messages are valid codewords here (every check covers an
      // even count), and bits above the codeword must be ignored.
      directed_rows = '{
         '{6'd4,  hcv_pkg::OP_ENCODE, 64'h0,                 1'b1,
           '{64'h0,                 7'd0,  hcv_pkg::STATUS_OK,           3'd3}},
         '{6'd4,  hcv_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7F,                7'd0,  hcv_pkg::STATUS_OK,           3'd3}},
         '{6'd4,  hcv_pkg::OP_DECODE, 64'h7F,                1'b1,
           '{64'h7F,                7'd0,  hcv_pkg::STATUS_OK,           3'd3}},
         '{6'd4,  hcv_pkg::OP_DECODE, 64'h7E,                1'b1,
           '{64'h7F,                7'd1,  hcv_pkg::STATUS_CORRECTED,    3'd3}},
         '{6'd4,  hcv_pkg::OP_DECODE, 64'h40,                1'b1,
           '{64'h0,                 7'd7,  hcv_pkg::STATUS_CORRECTED,    3'd3}},
         '{6'd4,  hcv_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7F,                7'd0,  hcv_pkg::STATUS_OK,           3'd3}},
         '{6'd4,  hcv_pkg::OP_ENCODE, 64'h5,                 1'b0, '0},
         '{6'd4,  hcv_pkg::OP_DECODE, 64'h33,                1'b0, '0},
         // A zero length is read as a single message bit.
         '{6'd0,  hcv_pkg::OP_ENCODE, 64'h1,                 1'b1,
           '{64'h7,                 7'd0,  hcv_pkg::STATUS_OK,           3'd2}},
         '{6'd0,  hcv_pkg::OP_ENCODE, 64'h0,                 1'b1,
           '{64'h0,                 7'd0,  hcv_pkg::STATUS_OK,           3'd2}},
         '{6'd0,  hcv_pkg::OP_DECODE, 64'h5,                 1'b1,
           '{64'h7,                 7'd2,  hcv_pkg::STATUS_CORRECTED,    3'd2}},
         // Five positions, three checks: syndrome six points past the end.
         '{6'd2,  hcv_pkg::OP_DECODE, 64'hA,                 1'b1,
           '{64'hA,                 7'd6,  hcv_pkg::STATUS_OUT_OF_RANGE, 3'd3}},
         '{6'd2,  hcv_pkg::OP_DECODE, 64'h1F,                1'b0, '0},
         '{6'd2,  hcv_pkg::OP_ENCODE, 64'h3,                 1'b0, '0},
         // An oversized length saturates to 57 message bits, 63 positions.
         '{6'd63, hcv_pkg::OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7FFF_FFFF_FFFF_FFFF, 7'd0,  hcv_pkg::STATUS_OK,         3'd6}},
         '{6'd63, hcv_pkg::OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
           '{64'h7FFF_FFFF_FFFF_FFFF, 7'd0,  hcv_pkg::STATUS_OK,         3'd6}},
         '{6'd63, hcv_pkg::OP_DECODE, 64'h4000_0000_0000_0000, 1'b1,
           '{64'h0,                 7'd63, hcv_pkg::STATUS_CORRECTED,    3'd6}},
         '{6'd63, hcv_pkg::OP_ENCODE, 64'h0123_4567_89AB_CDEF, 1'b0, '0},
         '{6'd57, hcv_pkg::OP_ENCODE, 64'h0,                 1'b1,
           '{64'h0,                 7'd0,  hcv_pkg::STATUS_OK,           3'd6}},
         '{6'd57, hcv_pkg::OP_DECODE, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0},
         '{6'd58, hcv_pkg::OP_ENCODE, 64'hFEDC_BA98_7654_3210, 1'b0, '0},
         '{6'd1,  hcv_pkg::OP_DECODE, 64'h7,                 1'b1,
           '{64'h7,                 7'd0,  hcv_pkg::STATUS_OK,           3'd2}},
         '{6'd4,  hcv_pkg::OP_ENCODE, 64'hA,                 1'b0, '0}
      };

      // Synchronous reset, released at a falling edge.
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      rcv_idle_pct  = 65;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_rows[i].msg_len != length_reg) write_length(directed_rows[i].msg_len);
         send_beat(directed_rows[i].op, directed_rows[i].word,
                   directed_rows[i].typed, directed_rows[i].result);
      end

      // Random part in three idle patterns: sender mostly busy with a slow
      // receiver, then the reverse, then both at full rate. Each pattern goes
      // through several length settings; every length write first waits for
      // all owed responses, which is also where the sender sits idle until
      // the block has emptied.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               rcv_idle_pct  = 65;
            end
            1: begin
               send_idle_pct = 65;
               rcv_idle_pct  = 7;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         for (int seg = 0; seg < SEGMENTS; seg++) begin
            if ($urandom_range(0, 1) == 1) next_len = extremes[$urandom_range(0, 7)];
            else next_len = NLEN_W'($urandom_range(0, 63));
            write_length(next_len);
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
               // Mid-segment, stall the receiver for a long stretch while
               // the sender keeps pushing.
               if (seg == 2 && k == 40) hold_ask = 1'b1;
               random_beat(op, word);
               send_beat(op, word, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_for_results();

      $display("covered %0d beats (%0d encode, %0d decode, %0d corrected, %0d past end)",
               beats_sent, encodes, decodes, corrections, out_of_range);
      $display("over %0d length writes and three idle patterns; %0d responses checked",
               length_writes, beats_checked);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("hamming_codec_variable_length_top_test: clean");
      end else begin
         $display("hamming_codec_variable_length_top_test: errors");
      end
      $finish;
   end

endmodule

[files.f]
rtl/hcv_pkg.sv
rtl/hcv_datapath.sv
rtl/hamming_codec_variable_length_top.sv
tb/hamming_codec_variable_length_top_test.sv
